>>> hw/rtl/stroke_ribbon_quad_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Stroke ribbon quad generator: assertion macros
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STROKE_RIBBON_QUAD_GENERATOR_UNIT_ASSERT_SVH
`define STROKE_RIBBON_QUAD_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SRQG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRQG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/srqg_pkg.sv
// ----------------------------------------------------------------------------
// srqg_pkg
// Types and constants shared by the stroke ribbon quad generator.
// ----------------------------------------------------------------------------
package srqg_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned CoordBits = 32;
  localparam int unsigned WidthBits = 31;
  localparam int unsigned CfgBits   = 16;
  localparam int unsigned QuotBits  = FracBits + 1;

  localparam logic [1:0] CFG_MIN_SEG_LEN = 2'd0;
  localparam logic [1:0] CFG_MIN_WIDTH   = 2'd1;

  localparam logic [CfgBits-1:0] MIN_SEG_LEN_RST = 16'd7;
  localparam logic [CfgBits-1:0] MIN_WIDTH_RST   = 16'd66;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  localparam logic [2:0] EMIT_A0 = 3'd0;
  localparam logic [2:0] EMIT_B0 = 3'd1;
  localparam logic [2:0] EMIT_B1 = 3'd2;
  localparam logic [2:0] EMIT_A1 = 3'd3;
  localparam logic [2:0] EMIT_T0 = 3'd4;
  localparam logic [2:0] EMIT_T1 = 3'd5;

  localparam logic [1:0] MUL_OXA = 2'd0;
  localparam logic [1:0] MUL_OYA = 2'd1;
  localparam logic [1:0] MUL_OXB = 2'd2;
  localparam logic [1:0] MUL_OYB = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SHIFT,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       load_in;
    logic       diff;
    logic       shift;
    logic       sqx;
    logic       sqy;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       emit_load;
    logic [2:0] emit_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic seg;
    logic skip;
    logic out_free;
  } dp_status_t;

endpackage

>>> hw/rtl/stroke_ribbon_quad_generator_unit.sv
// ----------------------------------------------------------------------------
// stroke_ribbon_quad_generator_unit
// Extrudes a stroke polyline into quads: four vertices and two triangles
// per segment.
//
//   channel   handshake                 payload
//   input     in_valid_i / in_ready_o   point_x/y, stroke_width, first_of_path
//   output    out_valid_o / out_ready_i kind, vertex_x/y, tex_u/v, corner_a/b/c, last
//   config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// A first point is only stored. A skipped segment runs up to the end of the
// 32-step square root. A full segment also runs the 17-step dividers and the
// offset multiplies before its first result, then gives 6 results at
// one per cycle when not stalled.
// Reset is asynchronous; no clearing pass. An item is taken only while idle;
// the output register holds the last result while the next item is taken.
// ----------------------------------------------------------------------------
module stroke_ribbon_quad_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic [30:0]        stroke_width_i,
  input  logic               first_of_path_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic signed [31:0] vertex_x_o,
  output logic signed [31:0] vertex_y_o,
  output logic               tex_u_o,
  output logic               tex_v_o,
  output logic [31:0]        corner_a_o,
  output logic [31:0]        corner_b_o,
  output logic [31:0]        corner_c_o,
  output logic               last_o
);
  import srqg_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  srqg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srqg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .stroke_width_i  (stroke_width_i),
    .first_of_path_i (first_of_path_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .vertex_x_o      (vertex_x_o),
    .vertex_y_o      (vertex_y_o),
    .tex_u_o         (tex_u_o),
    .tex_v_o         (tex_v_o),
    .corner_a_o      (corner_a_o),
    .corner_b_o      (corner_b_o),
    .corner_c_o      (corner_c_o),
    .last_o          (last_o)
  );

endmodule

>>> hw/rtl/srqg_ctrl.sv
// ----------------------------------------------------------------------------
// srqg_ctrl
// Sequencer: steps the datapath through diff, sqrt, divide, multiply, emit.
// ----------------------------------------------------------------------------
`include "stroke_ribbon_quad_generator_unit_assert.svh"

module srqg_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  srqg_pkg::dp_status_t  status_i,
  output srqg_pkg::ctl_cmd_t    cmd_o
);
  import srqg_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          if (status_i.seg) state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.sqx = 1'b1;
        state_d   = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.sqy = 1'b1;
        cnt_d     = '0;
        state_d   = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == 5'd31) begin
          state_d = ST_CHECK;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_CHECK: begin
        cnt_d = '0;
        if (status_i.skip) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == 5'(QuotBits - 1)) begin
          cnt_d   = '0;
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = cnt_q[1:0];
        if (cnt_q[1:0] == MUL_OYB) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_idx = cnt_q[2:0];
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (cnt_q[2:0] == EMIT_T1) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q + 5'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `SRQG_ASSERT_NXT(a_emit_done, cmd_o.emit_load && cmd_o.emit_idx == EMIT_T1, state_q == ST_IDLE, "segment did not end after last result")
  `SRQG_ASSERT_IMP(a_emit_idx, state_q == ST_EMIT, cnt_q <= 5'd5, "emit index out of range")
  `SRQG_ASSERT_IMP(a_emit_entry, state_q == ST_EMIT && $past(state_q) != ST_EMIT, $past(state_q) == ST_MUL, "emit entered without offsets")

endmodule

>>> hw/rtl/srqg_dp.sv
// ----------------------------------------------------------------------------
// srqg_dp
// Datapath: state, sqrt, two dividers, shared multiplier, output register.
// ----------------------------------------------------------------------------
module srqg_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic signed [31:0]    point_x_i,
  input  logic signed [31:0]    point_y_i,
  input  logic [30:0]           stroke_width_i,
  input  logic                  first_of_path_i,
  input  srqg_pkg::ctl_cmd_t    cmd_i,
  output srqg_pkg::dp_status_t  status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  kind_o,
  output logic signed [31:0]    vertex_x_o,
  output logic signed [31:0]    vertex_y_o,
  output logic                  tex_u_o,
  output logic                  tex_v_o,
  output logic [31:0]           corner_a_o,
  output logic [31:0]           corner_b_o,
  output logic [31:0]           corner_c_o,
  output logic                  last_o
);
  import srqg_pkg::*;

  logic [CfgBits-1:0]   min_len_q, min_w_q;
  logic [31:0]          prev_x_q, prev_y_q, vcount_q;
  logic [WidthBits-1:0] prev_w_q;
  logic                 prev_valid_q;

  logic [31:0]          ax_q, ay_q, bx_q, by_q;
  logic [WidthBits-1:0] aw_q, bw_q;
  logic [32:0]          adx_q, ady_q;
  logic                 dx_neg_q, dy_pos_q;
  logic [30:0]          mx_q, my_q;
  logic [1:0]           s_q;
  logic [61:0]          sq_q;
  logic [63:0]          rad_q, res_q, bit_q;
  logic [31:0]          remx_q, remy_q;
  logic                 nx_q, ny_q;
  logic [QuotBits-1:0]  ux_q, uy_q;
  logic [30:0]          oxa_q, oya_q, oxb_q, oyb_q;
  logic                 out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q    <= MIN_SEG_LEN_RST;
      min_w_q      <= MIN_WIDTH_RST;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_w_q     <= '0;
      prev_valid_q <= 1'b0;
      vcount_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_MIN_SEG_LEN) min_len_q <= cfg_wdata_i;
      if (cfg_we_i && cfg_idx_i == CFG_MIN_WIDTH) min_w_q <= cfg_wdata_i;
      if (cmd_i.load_in) begin
        prev_x_q     <= point_x_i;
        prev_y_q     <= point_y_i;
        prev_w_q     <= stroke_width_i;
        prev_valid_q <= 1'b1;
      end
      if (cmd_i.emit_load && cmd_i.emit_idx == EMIT_T1) vcount_q <= vcount_q + 32'd4;
      if (cmd_i.emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.seg      = prev_valid_q && !first_of_path_i;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

  // segment geometry
  logic [32:0] dx, dy, d;
  logic [1:0]  s;
  logic [32:0] mx_w, my_w;
  assign dx = {bx_q[31], bx_q} - {ax_q[31], ax_q};
  assign dy = {by_q[31], by_q} - {ay_q[31], ay_q};
  assign d  = (adx_q > ady_q) ? adx_q : ady_q;
  always_comb begin
    if (d[32])      s = 2'd2;
    else if (d[31]) s = 2'd1;
    else            s = 2'd0;
  end
  assign mx_w = adx_q >> s;
  assign my_w = ady_q >> s;

  // sqrt step
  logic [63:0] sq_t;
  assign sq_t = res_q + bit_q;

  // length test
  logic [33:0] len;
  assign len = {2'b00, res_q[31:0]} << s_q;
  assign status_o.skip = (res_q[31:0] == '0) || (len <= {18'd0, min_len_q});

  // divide steps
  logic [32:0] tx, ty;
  logic        gex, gey;
  assign tx  = {remx_q, nx_q};
  assign ty  = {remy_q, ny_q};
  assign gex = tx >= {1'b0, res_q[31:0]};
  assign gey = ty >= {1'b0, res_q[31:0]};

  // offset multiply
  logic [WidthBits-1:0] wa, wb, mw;
  logic [QuotBits-1:0]  mu;
  logic [47:0]          prod;
  assign wa = (aw_q > {15'd0, min_w_q}) ? aw_q : {15'd0, min_w_q};
  assign wb = (bw_q > {15'd0, min_w_q}) ? bw_q : {15'd0, min_w_q};
  assign mu = cmd_i.mul_sel[0] ? ux_q : uy_q;
  assign mw = cmd_i.mul_sel[1] ? wb : wa;
  assign prod = {31'd0, mu} * {17'd0, mw};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ax_q <= prev_x_q;
      ay_q <= prev_y_q;
      aw_q <= prev_w_q;
      bx_q <= point_x_i;
      by_q <= point_y_i;
      bw_q <= stroke_width_i;
    end
    if (cmd_i.diff) begin
      adx_q    <= dx[32] ? -dx : dx;
      ady_q    <= dy[32] ? -dy : dy;
      dx_neg_q <= dx[32];
      dy_pos_q <= !dy[32] && (dy != '0);
    end
    if (cmd_i.shift) begin
      mx_q <= mx_w[30:0];
      my_q <= my_w[30:0];
      s_q  <= s;
    end
    if (cmd_i.sqx) sq_q <= {31'd0, mx_q} * {31'd0, mx_q};
    if (cmd_i.sqy) begin
      rad_q <= {2'b00, sq_q} + ({33'd0, my_q} * {33'd0, my_q});
      res_q <= '0;
      bit_q <= 64'd1 << 62;
    end
    if (cmd_i.sqrt_step) begin
      if (rad_q >= sq_t) begin
        rad_q <= rad_q - sq_t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      remx_q <= {2'b00, mx_q[30:1]};
      remy_q <= {2'b00, my_q[30:1]};
      nx_q   <= mx_q[0];
      ny_q   <= my_q[0];
      ux_q   <= '0;
      uy_q   <= '0;
    end
    if (cmd_i.div_step) begin
      remx_q <= gex ? 32'(tx - {1'b0, res_q[31:0]}) : tx[31:0];
      remy_q <= gey ? 32'(ty - {1'b0, res_q[31:0]}) : ty[31:0];
      nx_q   <= 1'b0;
      ny_q   <= 1'b0;
      ux_q   <= {ux_q[QuotBits-2:0], gex};
      uy_q   <= {uy_q[QuotBits-2:0], gey};
    end
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_OXA: oxa_q <= prod[47:QuotBits];
        MUL_OYA: oya_q <= prod[47:QuotBits];
        MUL_OXB: oxb_q <= prod[47:QuotBits];
        MUL_OYB: oyb_q <= prod[47:QuotBits];
        default: oxa_q <= prod[47:QuotBits];
      endcase
    end
  end

  // result select
  logic        minus, use_b, is_tri;
  logic [31:0] px, py;
  logic [30:0] ox, oy;
  logic [33:0] vx, vy;
  logic [31:0] sx, sy;

  always_comb begin
    minus  = 1'b0;
    use_b  = 1'b0;
    is_tri = 1'b0;
    case (cmd_i.emit_idx)
      EMIT_A0: begin minus = 1'b1; use_b = 1'b0; end
      EMIT_B0: begin minus = 1'b1; use_b = 1'b1; end
      EMIT_B1: begin minus = 1'b0; use_b = 1'b1; end
      EMIT_A1: begin minus = 1'b0; use_b = 1'b0; end
      default: is_tri = 1'b1;
    endcase
    px = use_b ? bx_q : ax_q;
    py = use_b ? by_q : ay_q;
    ox = use_b ? oxb_q : oxa_q;
    oy = use_b ? oyb_q : oya_q;
    vx = (minus ^ dy_pos_q) ? {{2{px[31]}}, px} - {3'd0, ox}
                            : {{2{px[31]}}, px} + {3'd0, ox};
    vy = (minus ^ dx_neg_q) ? {{2{py[31]}}, py} - {3'd0, oy}
                            : {{2{py[31]}}, py} + {3'd0, oy};
    if (vx[33:31] == 3'b000 || vx[33:31] == 3'b111) sx = vx[31:0];
    else sx = vx[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (vy[33:31] == 3'b000 || vy[33:31] == 3'b111) sy = vy[31:0];
    else sy = vy[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      kind_o     <= is_tri ? KIND_TRIANGLE : KIND_VERTEX;
      vertex_x_o <= is_tri ? '0 : sx;
      vertex_y_o <= is_tri ? '0 : sy;
      tex_u_o    <= !is_tri && use_b;
      tex_v_o    <= !is_tri && !minus;
      corner_a_o <= is_tri ? vcount_q : '0;
      corner_b_o <= !is_tri ? '0 :
                    (cmd_i.emit_idx == EMIT_T0) ? vcount_q + 32'd1 : vcount_q + 32'd2;
      corner_c_o <= !is_tri ? '0 :
                    (cmd_i.emit_idx == EMIT_T0) ? vcount_q + 32'd2 : vcount_q + 32'd3;
      last_o     <= cmd_i.emit_idx == EMIT_T1;
    end
  end

endmodule
